// ===== hdl/sdf_pkg.sv =====
// shared types and codes for the sequence duplicate filter
// no dependencies
package sdf_pkg;

  localparam int MAC_W   = 48;
  localparam int TYPE_W  = 8;
  localparam int SEQ_W   = 16;
  localparam int INDEX_W = 6;

  localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h8000;

  localparam logic [1:0] OUT_UPDATED  = 2'd0;
  localparam logic [1:0] OUT_DROPPED  = 2'd1;
  localparam logic [1:0] OUT_NEW      = 2'd2;
  localparam logic [1:0] OUT_REPLACED = 2'd3;

  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [TYPE_W-1:0] message_type;
    logic [SEQ_W-1:0]  sequence_number;
  } sdf_in_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         outcome;
    logic [INDEX_W-1:0] entry_index;
  } sdf_out_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
  } sdf_cmd_t;

  typedef struct packed {
    logic resolve;
  } sdf_sts_t;

endpackage

// ===== hdl/sdf_ctrl.sv =====
// controller: request handshake, table scan sequencing, result register valid
// depends on sdf_pkg
module sdf_ctrl import sdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  sdf_sts_t sts,
  output sdf_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.scan_en = (state_r == S_SCAN) && !sts.resolve;
    cmd.commit  = (state_r == S_SCAN) && sts.resolve && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/sdf_dpath.sv =====
// datapath: stream table memory, valid bits, compare, window check, result register
// depends on sdf_pkg
module sdf_dpath import sdf_pkg::*; #(
  parameter int N = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sdf_in_t  in_data,
  input  sdf_cmd_t cmd,
  output sdf_sts_t sts,
  output sdf_out_t out_data
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  sdf_in_t         mem [N];
  sdf_in_t         item_r;
  sdf_in_t         rd_q;
  logic [N-1:0]    valid_r;
  logic [IW-1:0]   scan_idx_r;
  logic [IW-1:0]   chk_idx_r;
  logic            chk_v_r;
  logic            free_found_r;
  logic [IW-1:0]   free_idx_r;
  sdf_out_t        out_r;

  logic            hit;
  logic            acc;
  logic [SEQ_W-1:0] diff;
  logic            free_any;
  logic [IW-1:0]   alloc_idx;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  sdf_out_t        res;

  assign hit = chk_v_r && valid_r[chk_idx_r]
             && (rd_q.src_mac == item_r.src_mac)
             && (rd_q.message_type == item_r.message_type);
  assign diff = item_r.sequence_number - rd_q.sequence_number;
  assign acc  = (diff != '0) && (diff <= HALF_RANGE);
  assign sts.resolve = chk_v_r && (hit || (chk_idx_r == LAST));

  always_comb begin
    free_any  = free_found_r || !valid_r[chk_idx_r];
    alloc_idx = '0;
    if (free_found_r) alloc_idx = free_idx_r;
    else if (!valid_r[chk_idx_r]) alloc_idx = chk_idx_r;
  end

  always_comb begin
    res.entry_index = INDEX_W'(chk_idx_r);
    if (hit) begin
      res.accepted = acc;
      res.outcome  = acc ? OUT_UPDATED : OUT_DROPPED;
    end else if (free_any) begin
      res.accepted    = 1'b1;
      res.outcome     = OUT_NEW;
      res.entry_index = INDEX_W'(alloc_idx);
    end else begin
      res.accepted    = 1'b1;
      res.outcome     = OUT_REPLACED;
      res.entry_index = '0;
    end
  end

  assign wr_en   = cmd.commit && (!hit || acc);
  assign wr_addr = hit ? chk_idx_r : alloc_idx;

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= item_r;
    if (cmd.scan_en) rd_q <= mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.commit) out_r <= res;
    if (cmd.load) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_en) begin
      chk_idx_r <= scan_idx_r;
      if (scan_idx_r != LAST) scan_idx_r <= scan_idx_r + 1'b1;
      if (chk_v_r && !valid_r[chk_idx_r] && !free_found_r) free_idx_r <= chk_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      chk_v_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        chk_v_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmd.scan_en) begin
        chk_v_r <= 1'b1;
        if (chk_v_r && !valid_r[chk_idx_r]) free_found_r <= 1'b1;
      end
      if (cmd.commit && !hit) valid_r[alloc_idx] <= 1'b1;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hdl/sequence_duplicate_filter.sv =====
// Sequence number duplicate filter. A request (source address, message type,
// sequence number) is taken while the block is idle, then the stream table is
// scanned from entry 0 upward, one entry per cycle through the single read port
// of the table memory, until a match or the last entry; the block is idle again,
// ready for the next request, once the result is written to the output register.
// A known stream passes when the wrapped sequence difference is 1..32768 and its
// stored number is then updated; an unknown stream takes the first free entry,
// or entry 0 when the table is full. Valid bits clear at reset, so no clearing
// pass is needed. The result waits in an output register, and a new request is
// taken while it is still pending.
// depends on sdf_pkg, sdf_ctrl, sdf_dpath
module sequence_duplicate_filter import sdf_pkg::*; #(
  parameter int TABLE_ENTRIES = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sdf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sdf_out_t out_data
);

  sdf_cmd_t cmd;
  sdf_sts_t sts;

  sdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdf_dpath #(.N(TABLE_ENTRIES)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.outcome != OUT_DROPPED)))
    else $error("verdict and outcome disagree");

  a_replace_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.outcome == OUT_REPLACED) |-> (out_data.entry_index == '0))
    else $error("table full overwrite not at entry 0");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_index < INDEX_W'(TABLE_ENTRIES)))
    else $error("entry index beyond table");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous still scanning");

endmodule

// ===== tb/tb_top.sv =====
// testbench for sequence_duplicate_filter: directed and random requests through
// a queue-fed driver, a table predictor and an in-order result checker
// depends on sdf_pkg and hdl/sequence_duplicate_filter.sv
`timescale 1ns / 1ps

module tb_top;
  import sdf_pkg::*;

  localparam int ENTRIES = 12;
  localparam int WD_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sdf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sdf_out_t out_data;

  sequence_duplicate_filter #(.TABLE_ENTRIES(ENTRIES)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // stream table mirror
  logic              tbl_valid [ENTRIES] = '{default: 1'b0};
  logic [MAC_W-1:0]  tbl_mac   [ENTRIES];
  logic [TYPE_W-1:0] tbl_type  [ENTRIES];
  logic [SEQ_W-1:0]  tbl_seq   [ENTRIES];

  sdf_in_t  pend_q[$];
  sdf_out_t verdict_q[$];

  // stream pool for random traffic
  logic [MAC_W-1:0]  key_mac[$];
  logic [TYPE_W-1:0] key_type[$];
  logic [SEQ_W-1:0]  key_seq[$];

  int idle_pct = 0;
  int stall_pct = 0;
  logic in_taken = 1'b0;
  int wd_cnt = 0;
  int fail_cnt = 0;
  int req_cnt = 0;
  int res_cnt = 0;
  int outcome_cnt [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sdf_out_t filter_verdict(input sdf_in_t req);
    sdf_out_t     res;
    logic [SEQ_W-1:0] diff;
    int           hit;
    int           slot;
    hit = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_type[i] == req.message_type &&
          tbl_mac[i] == req.src_mac)
        hit = i;
    end
    if (hit >= 0) begin
      diff = req.sequence_number - tbl_seq[hit];
      if (diff == '0 || diff > HALF_RANGE) begin
        res.accepted = 1'b0;
        res.outcome = OUT_DROPPED;
      end else begin
        tbl_seq[hit] = req.sequence_number;
        res.accepted = 1'b1;
        res.outcome = OUT_UPDATED;
      end
      res.entry_index = hit[INDEX_W-1:0];
      return res;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && !tbl_valid[i]) slot = i;
    end
    if (slot >= 0) res.outcome = OUT_NEW;
    else begin
      slot = 0;
      res.outcome = OUT_REPLACED;
    end
    tbl_valid[slot] = 1'b1;
    tbl_mac[slot] = req.src_mac;
    tbl_type[slot] = req.message_type;
    tbl_seq[slot] = req.sequence_number;
    res.accepted = 1'b1;
    res.entry_index = slot[INDEX_W-1:0];
    return res;
  endfunction

  // request driver
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!in_valid || in_taken) begin
      if (pend_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // request capture and prediction
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (in_valid && !in_stall) begin
      verdict_q.push_back(filter_verdict(in_data));
      req_cnt++;
    end
  end

  // result checker
  always @(posedge clk) begin
    sdf_out_t want;
    if (out_valid && !out_stall) begin
      res_cnt++;
      if (verdict_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("tb_top: unexpected result acc=%0d outcome=%0d index=%0d",
                   out_data.accepted, out_data.outcome, out_data.entry_index);
      end else begin
        want = verdict_q.pop_front();
        outcome_cnt[want.outcome]++;
        if (out_data.accepted !== want.accepted || out_data.outcome !== want.outcome ||
            out_data.entry_index !== want.entry_index) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"tb_top: mismatch at result %0d: expected acc=%0d outcome=%0d ",
                      "index=%0d, got acc=%0d outcome=%0d index=%0d"},
                     res_cnt, want.accepted, want.outcome, want.entry_index,
                     out_data.accepted, out_data.outcome, out_data.entry_index);
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wd_cnt <= 0;
    else wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_LIMIT) begin
      $display("tb_top: watchdog expired with %0d results outstanding", verdict_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic push_req(input logic [MAC_W-1:0] mac, input logic [TYPE_W-1:0] mt,
                          input logic [SEQ_W-1:0] seq);
    sdf_in_t req;
    req.src_mac = mac;
    req.message_type = mt;
    req.sequence_number = seq;
    pend_q.push_back(req);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] m;
    m[47:32] = 16'($urandom);
    m[31:0] = $urandom;
    return m;
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pend_q.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  task automatic gen_random(input int count);
    int nkeys;
    int k;
    int roll;
    logic [SEQ_W-1:0] step;
    logic [SEQ_W-1:0] seq;
    key_mac.delete();
    key_type.delete();
    key_seq.delete();
    nkeys = $urandom_range(3, 18);
    for (int i = 0; i < nkeys; i++) begin
      roll = $urandom_range(0, 3);
      if (i > 0 && roll == 0) begin
        key_mac.push_back(key_mac[i-1]);
        key_type.push_back(key_type[i-1] + 8'd1);
      end else if (i > 0 && roll == 1) begin
        key_mac.push_back(rand_mac());
        key_type.push_back(key_type[i-1]);
      end else begin
        key_mac.push_back(rand_mac());
        key_type.push_back(8'($urandom));
      end
      key_seq.push_back(16'($urandom));
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 12) begin
        push_req(rand_mac(), 8'($urandom), 16'($urandom));
      end else begin
        k = $urandom_range(0, nkeys - 1);
        roll = $urandom_range(0, 99);
        if (roll < 65) step = 16'($urandom_range(1, 4));
        else if (roll < 75) step = '0;
        else if (roll < 82) step = HALF_RANGE;
        else if (roll < 88) step = HALF_RANGE + 16'd1;
        else if (roll < 94) step = 16'd0 - 16'($urandom_range(1, 3));
        else step = 16'($urandom);
        seq = key_seq[k] + step;
        if (step != '0 && step <= HALF_RANGE) key_seq[k] = seq;
        push_req(key_mac[k], key_type[k], seq);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // new stream, duplicate, half range, stale and wrap on the all-zero key
    push_req(48'h0, 8'h00, 16'd0);
    push_req(48'h0, 8'h00, 16'd0);
    push_req(48'h0, 8'h00, 16'd1);
    push_req(48'h0, 8'h00, 16'd32769);
    push_req(48'h0, 8'h00, 16'd2);
    push_req(48'h0, 8'h00, 16'd32768);
    push_req(48'h0, 8'h00, 16'd65535);
    push_req(48'h0, 8'h00, 16'd0);
    // all-ones key and keys that share only address or only type
    push_req(48'hFFFF_FFFF_FFFF, 8'hFF, 16'd65535);
    push_req(48'hFFFF_FFFF_FFFF, 8'h00, 16'd100);
    push_req(48'h0, 8'hFF, 16'd5);
    push_req(48'hFFFF_FFFF_FFFF, 8'hFF, 16'd65535);
    push_req(48'hFFFF_FFFF_FFFF, 8'hFF, 16'd0);
    // fill the table, then overwrite entry 0
    for (int k = 0; k < 8; k++)
      push_req(48'h1 << (k * 6), 8'(k + 1), 16'(k * 1000));
    push_req(48'hA5A5_5A5A_0F0F, 8'h5A, 16'h1234);
    push_req(48'h0, 8'h00, 16'd1);
    push_req(48'hFFFF_FFFF_FFFF, 8'hFF, 16'd1);
    wait_drained();

    gen_random(215);
    wait_drained();

    idle_pct = 70;
    gen_random(210);
    wait_drained();

    idle_pct = 0;
    stall_pct = 70;
    gen_random(210);
    wait_drained();

    idle_pct = 7;
    stall_pct = 7;
    gen_random(215);
    wait_drained();

    idle_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    if (verdict_q.size() != 0) fail_cnt += verdict_q.size();

    $display("tb_top: %0d requests, %0d results (updated %0d, dropped %0d, new %0d, %s)",
             req_cnt, res_cnt, outcome_cnt[OUT_UPDATED], outcome_cnt[OUT_DROPPED],
             outcome_cnt[OUT_NEW], $sformatf("replaced %0d", outcome_cnt[OUT_REPLACED]));
    $display("tb_top: idle and stall phases covered, %0d failures", fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sdf_pkg.sv
hdl/sdf_ctrl.sv
hdl/sdf_dpath.sv
hdl/sequence_duplicate_filter.sv
tb/tb_top.sv
